// File: hw/rtl/olkfe_pkg.sv
// Package for the ordered list with k-th-from-end read.
// Holds the operation and status codes, the field widths and the default depth.
// No dependencies.
`default_nettype none

package olkfe_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam int IN_FIELDS_W  = OP_W + POS_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ST_W + VAL_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [OP_W-1:0] OP_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP      = 8'b0000_0010,
        S_UP_LAST = 8'b0000_0100,
        S_PLACE   = 8'b0000_1000,
        S_DN      = 8'b0001_0000,
        S_DN_LAST = 8'b0010_0000,
        S_RWAIT   = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ordered_list_with_kth_from_end.sv
// Ordered list of up to DEPTH values held in one synchronous memory.
// An insert moves the entries from the insert point to the tail up one place and a delete
// moves the entries behind the deleted one down one place, through the single read and
// single write port of the list memory, one entry a cycle; no request is taken meanwhile.
// A finished result waits in the output register while the next request is taken.
// Reset empties the list at once; the memory contents are left as they are.
`default_nettype none

module ordered_list_with_kth_from_end #(
    parameter int DEPTH = olkfe_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // operation [2:0], position [7:3], value [39:8]
    input  wire logic [olkfe_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // status [1:0], read_value [33:2], length [38:34], zero fill above
    output logic [olkfe_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > olkfe_pkg::POS_W) ? CW : olkfe_pkg::POS_W) + 1;

    olkfe_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic [AW-1:0]                     end_reg, end_next;
    logic [olkfe_pkg::VAL_W-1:0]       val_reg, val_next;
    logic                              pend_reg, pend_next;
    logic [AW-1:0]                     pend_addr_reg, pend_addr_next;
    logic [olkfe_pkg::ST_W-1:0]        res_status_reg, res_status_next;
    logic [olkfe_pkg::VAL_W-1:0]       res_value_reg, res_value_next;
    logic                              m_valid_reg, m_valid_next;
    logic [olkfe_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [olkfe_pkg::VAL_W-1:0] mem [DEPTH];
    logic [olkfe_pkg::VAL_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [olkfe_pkg::VAL_W-1:0] wr_data;

    logic [olkfe_pkg::OP_W-1:0]  in_op;
    logic [olkfe_pkg::POS_W-1:0] in_pos;
    logic [olkfe_pkg::VAL_W-1:0] in_val;
    logic [EW-1:0]               pos_e;
    logic [EW-1:0]               cnt_e;
    logic [EW-1:0]               cnt_dec_e;
    logic [EW-1:0]               rd_off_e;
    logic [EW-1:0]               pos_dec_e;
    logic                        full;
    logic                        out_free;

    assign in_op  = s_tdata[olkfe_pkg::OP_W-1:0];
    assign in_pos = s_tdata[olkfe_pkg::OP_W +: olkfe_pkg::POS_W];
    assign in_val = s_tdata[olkfe_pkg::OP_W + olkfe_pkg::POS_W +: olkfe_pkg::VAL_W];

    assign pos_e     = EW'(in_pos);
    assign cnt_e     = EW'(count_reg);
    assign cnt_dec_e = cnt_e - EW'(1);
    assign rd_off_e  = cnt_e - pos_e;
    assign pos_dec_e = pos_e - EW'(1);
    assign full      = (count_reg == CW'(DEPTH));
    assign out_free  = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == olkfe_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        logic [EW-1:0] ins_e;
        logic          do_ins;

        ins_e  = '0;
        do_ins = 1'b0;

        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        val_next        = val_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_tdata_next    = m_tdata_reg;

        rd_en   = 1'b0;
        rd_addr = rd_ptr_reg;
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rd_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            olkfe_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = olkfe_pkg::ST_OK;
                    res_value_next  = '0;
                    val_next        = in_val;
                    state_next      = olkfe_pkg::S_FINISH;
                    unique case (in_op)
                        olkfe_pkg::OP_HEAD:
                        begin
                            if (full)
                                res_status_next = olkfe_pkg::ST_FULL;
                            else
                            begin
                                do_ins = 1'b1;
                                ins_e  = '0;
                            end
                        end
                        olkfe_pkg::OP_TAIL:
                        begin
                            if (full)
                                res_status_next = olkfe_pkg::ST_FULL;
                            else
                            begin
                                do_ins = 1'b1;
                                ins_e  = cnt_e;
                            end
                        end
                        olkfe_pkg::OP_POS:
                        begin
                            priority if (pos_e == '0 || pos_e > cnt_e + EW'(1))
                                res_status_next = olkfe_pkg::ST_RANGE;
                            else if (full)
                                res_status_next = olkfe_pkg::ST_FULL;
                            else
                            begin
                                do_ins = 1'b1;
                                ins_e  = pos_dec_e;
                            end
                        end
                        olkfe_pkg::OP_DEL:
                        begin
                            if (pos_e == '0 || pos_e > cnt_e)
                                res_status_next = olkfe_pkg::ST_RANGE;
                            else
                            begin
                                count_next = CW'(cnt_dec_e);
                                // Deleting the tail moves nothing.
                                if (pos_e != cnt_e)
                                begin
                                    rd_ptr_next = pos_e[AW-1:0];
                                    end_next    = cnt_dec_e[AW-1:0];
                                    state_next  = olkfe_pkg::S_DN;
                                end
                            end
                        end
                        olkfe_pkg::OP_READ:
                        begin
                            if (pos_e == '0 || pos_e > cnt_e)
                                res_status_next = olkfe_pkg::ST_RANGE;
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = rd_off_e[AW-1:0];
                                state_next = olkfe_pkg::S_RWAIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = olkfe_pkg::ST_RANGE;
                        end
                    endcase

                    if (do_ins)
                    begin
                        count_next = CW'(cnt_e + EW'(1));
                        idx_next   = ins_e[AW-1:0];
                        if (ins_e == cnt_e)
                        begin
                            // Appending: nothing to move, write the value straight away.
                            wr_en   = 1'b1;
                            wr_addr = ins_e[AW-1:0];
                            wr_data = in_val;
                        end
                        else
                        begin
                            rd_ptr_next = cnt_dec_e[AW-1:0];
                            state_next  = olkfe_pkg::S_UP;
                        end
                    end
                end
            end

            // Move entries up one place, from the tail down to the insert point.
            // Each read is written back in the following cycle, one address above where it came from.
            olkfe_pkg::S_UP:
            begin
                rd_en          = 1'b1;
                rd_addr        = rd_ptr_reg;
                wr_en          = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = rd_ptr_reg + AW'(1);
                rd_ptr_next    = rd_ptr_reg - AW'(1);
                if (rd_ptr_reg == idx_reg)
                    state_next = olkfe_pkg::S_UP_LAST;
            end

            olkfe_pkg::S_UP_LAST:
            begin
                wr_en      = 1'b1;
                state_next = olkfe_pkg::S_PLACE;
            end

            olkfe_pkg::S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = val_reg;
                state_next = olkfe_pkg::S_FINISH;
            end

            olkfe_pkg::S_DN:
            begin
                rd_en          = 1'b1;
                rd_addr        = rd_ptr_reg;
                wr_en          = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = rd_ptr_reg - AW'(1);
                rd_ptr_next    = rd_ptr_reg + AW'(1);
                if (rd_ptr_reg == end_reg)
                    state_next = olkfe_pkg::S_DN_LAST;
            end

            olkfe_pkg::S_DN_LAST:
            begin
                wr_en      = 1'b1;
                state_next = olkfe_pkg::S_FINISH;
            end

            olkfe_pkg::S_RWAIT:
            begin
                res_value_next = rd_data_reg;
                state_next     = olkfe_pkg::S_FINISH;
            end

            olkfe_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {{olkfe_pkg::OUT_PAD_W{1'b0}},
                                    cnt_e[olkfe_pkg::LEN_W-1:0],
                                    res_value_reg,
                                    res_status_reg};
                    state_next   = olkfe_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = olkfe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= olkfe_pkg::S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        val_reg        <= val_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire
